FILE: hw/rtl/elwbc_pkg.sv
package elwbc_pkg;

   localparam int LINE_BYTES = 32;
   localparam int ADDR_W     = 19;
   localparam int DATA_W     = 8;
   localparam int OFF_W      = $clog2(LINE_BYTES);
   localparam int TAG_W      = ADDR_W - OFF_W;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_FILL  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_READ     = 2'd0,
      KIND_WB       = 2'd1,
      KIND_FILL_REQ = 2'd2,
      KIND_DONE     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SCAN_LOAD,
      ST_RD_ISSUE,
      ST_RD_LOAD
   } state_type;

   typedef enum logic [1:0] {
      RSEL_OFFSET,
      RSEL_PENDING,
      RSEL_SCAN
   } rsel_type;

   typedef enum logic [2:0] {
      OSEL_READ,
      OSEL_FAIL,
      OSEL_FILL_REQ,
      OSEL_WB,
      OSEL_DONE
   } osel_type;

   typedef struct packed {
      logic     capture;
      logic     mem_rd;
      rsel_type rd_sel;
      logic     fill_write;
      logic     fill_done;
      logic     fill_fail;
      logic     write_hit;
      logic     fill_req;
      logic     scan_start;
      logic     scan_next;
      logic     scan_hit;
      logic     scan_end;
      logic     out_load;
      osel_type out_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    fill_ok;
      logic    pending;
      logic    modified;
      logic    valid;
      logic    tag_hit;
      logic    fill_last;
      logic    scan_dirty;
      logic    scan_at_end;
      logic    out_free;
   } dp_status_type;

endpackage

FILE: hw/rtl/eeprom_line_write_back_cache_core.sv
// channel  direction  handshake              payload
// req      in         req_valid / req_ready  command, address, byte_data, fill_ok
// rsp      out        rsp_valid / rsp_ready  kind, mem_address, out_data, run_start,
//                                            read_ok, last
//
// An accepted transaction is decoded in the next cycle; a read hit and the end of a line fill
// also wait for the registered line memory read. A flush of a modified line walks all 32 offsets,
// reading each dirty byte through the one memory read port and the one result register, then
// decodes again.
// Reset is synchronous and clears the line state and dirty flags; line data is not cleared.
// A stalled rsp_ready holds the result register, stops the flush walk at the next dirty byte
// and holds any result that is due; req_ready is high only while the controller is idle.
module eeprom_line_write_back_cache_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic [elwbc_pkg::ADDR_W-1:0]  req_address,
   input  logic [elwbc_pkg::DATA_W-1:0]  req_byte_data,
   input  logic                          req_fill_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_kind,
   output logic [elwbc_pkg::ADDR_W-1:0]  rsp_mem_address,
   output logic [elwbc_pkg::DATA_W-1:0]  rsp_out_data,
   output logic                          rsp_run_start,
   output logic                          rsp_read_ok,
   output logic                          rsp_last
);
   import elwbc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type st;

   elwbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   elwbc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .st              (st),
      .req_command     (req_command),
      .req_address     (req_address),
      .req_byte_data   (req_byte_data),
      .req_fill_ok     (req_fill_ok),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_mem_address (rsp_mem_address),
      .rsp_out_data    (rsp_out_data),
      .rsp_run_start   (rsp_run_start),
      .rsp_read_ok     (rsp_read_ok),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: hw/rtl/elwbc_ctrl.sv
module elwbc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  elwbc_pkg::dp_status_type st,
   output elwbc_pkg::ctrl_cmd_type  cmd
);
   import elwbc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (st.pending) begin
               if (st.cmd != CMD_FILL) begin
                  state_in = ST_IDLE;
               end else if (!st.fill_ok) begin
                  if (st.out_free) state_in = ST_IDLE;
               end else if (st.fill_last) begin
                  state_in = ST_RD_ISSUE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               case (st.cmd)
                  CMD_WRITE: begin
                     if (!st.tag_hit && st.modified) state_in = ST_SCAN;
                     else state_in = ST_IDLE;
                  end
                  CMD_READ: begin
                     if (st.modified) begin
                        state_in = ST_SCAN;
                     end else if (!st.tag_hit || !st.valid) begin
                        if (st.out_free) state_in = ST_IDLE;
                     end else begin
                        state_in = ST_RD_LOAD;
                     end
                  end
                  CMD_FLUSH: begin
                     if (st.modified) state_in = ST_SCAN;
                     else if (st.out_free) state_in = ST_IDLE;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            if (st.scan_dirty) state_in = ST_SCAN_LOAD;
            else if (st.scan_at_end) state_in = ST_DECODE;
         end
         ST_SCAN_LOAD: begin
            if (st.out_free) begin
               if (st.scan_at_end) state_in = ST_DECODE;
               else state_in = ST_SCAN;
            end
         end
         ST_RD_ISSUE: state_in = ST_RD_LOAD;
         ST_RD_LOAD: begin
            if (st.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECODE: begin
            if (st.pending) begin
               if (st.cmd == CMD_FILL) begin
                  if (!st.fill_ok) begin
                     if (st.out_free) begin
                        cmd.fill_fail = 1'b1;
                        cmd.out_load  = 1'b1;
                        cmd.out_sel   = OSEL_FAIL;
                     end
                  end else begin
                     cmd.fill_write = 1'b1;
                     cmd.fill_done  = st.fill_last;
                  end
               end
            end else begin
               case (st.cmd)
                  CMD_WRITE: begin
                     if (!st.tag_hit && st.modified) cmd.scan_start = 1'b1;
                     else cmd.write_hit = 1'b1;
                  end
                  CMD_READ: begin
                     if (st.modified) begin
                        cmd.scan_start = 1'b1;
                     end else if (!st.tag_hit || !st.valid) begin
                        if (st.out_free) begin
                           cmd.fill_req = 1'b1;
                           cmd.out_load = 1'b1;
                           cmd.out_sel  = OSEL_FILL_REQ;
                        end
                     end else begin
                        cmd.mem_rd = 1'b1;
                        cmd.rd_sel = RSEL_OFFSET;
                     end
                  end
                  CMD_FLUSH: begin
                     if (st.modified) begin
                        cmd.scan_start = 1'b1;
                     end else if (st.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = OSEL_DONE;
                     end
                  end
                  default: cmd = '0;
               endcase
            end
         end
         ST_SCAN: begin
            if (st.scan_dirty) begin
               cmd.mem_rd = 1'b1;
               cmd.rd_sel = RSEL_SCAN;
            end else if (st.scan_at_end) begin
               cmd.scan_end = 1'b1;
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_SCAN_LOAD: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OSEL_WB;
               if (st.scan_at_end) begin
                  cmd.scan_end = 1'b1;
               end else begin
                  cmd.scan_next = 1'b1;
                  cmd.scan_hit  = 1'b1;
               end
            end
         end
         ST_RD_ISSUE: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = RSEL_PENDING;
         end
         ST_RD_LOAD: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OSEL_READ;
            end
         end
         default: cmd = '0;
      endcase
   end

   a_scan_needs_modified: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN || state_ff == ST_SCAN_LOAD) |-> st.modified)
      else $error("flush scan running on a clean line");

   a_no_idle_while_pending_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_ISSUE) |-> ($past(state_ff) == ST_DECODE && st.valid))
      else $error("fill completion read without a valid line");

endmodule

FILE: hw/rtl/elwbc_dp.sv
module elwbc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  elwbc_pkg::ctrl_cmd_type             cmd,
   output elwbc_pkg::dp_status_type            st,
   input  logic [1:0]                          req_command,
   input  logic [elwbc_pkg::ADDR_W-1:0]        req_address,
   input  logic [elwbc_pkg::DATA_W-1:0]        req_byte_data,
   input  logic                                req_fill_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_kind,
   output logic [elwbc_pkg::ADDR_W-1:0]        rsp_mem_address,
   output logic [elwbc_pkg::DATA_W-1:0]        rsp_out_data,
   output logic                                rsp_run_start,
   output logic                                rsp_read_ok,
   output logic                                rsp_last
);
   import elwbc_pkg::*;

   // captured transaction
   cmd_type             cmd_ff, cmd_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [DATA_W-1:0]   data_ff, data_in;
   logic                ok_ff, ok_in;

   // line state
   logic [TAG_W-1:0]      tag_ff, tag_in;
   logic                  valid_ff, valid_in;
   logic                  modified_ff, modified_in;
   logic                  pending_ff, pending_in;
   logic [OFF_W-1:0]      pos_ff, pos_in;
   logic [OFF_W-1:0]      pend_off_ff, pend_off_in;
   logic [LINE_BYTES-1:0] dirty_ff, dirty_in;
   logic [OFF_W-1:0]      idx_ff, idx_in;
   logic                  prev_ff, prev_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              kind_ff, kind_in;
   logic [ADDR_W-1:0]     maddr_ff, maddr_in;
   logic [DATA_W-1:0]     odata_ff, odata_in;
   logic                  rs_ff, rs_in;
   logic                  rok_ff, rok_in;
   logic                  last_ff, last_in;

   // line memory
   logic [DATA_W-1:0]     line_mem_ff [LINE_BYTES];
   logic [DATA_W-1:0]     rd_data_ff;
   logic                  wr_en;
   logic [OFF_W-1:0]      wr_addr;
   logic [OFF_W-1:0]      rd_addr;

   logic [TAG_W-1:0]      req_tag;
   logic [OFF_W-1:0]      req_off;
   logic [LINE_BYTES-1:0] above_mask;
   logic                  more_dirty;
   logic                  out_free;

   assign req_tag  = addr_ff[ADDR_W-1:OFF_W];
   assign req_off  = addr_ff[OFF_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      for (int i = 0; i < LINE_BYTES; i++) begin
         above_mask[i] = (i > int'(idx_ff));
      end
   end
   assign more_dirty = |(dirty_ff & above_mask);

   assign wr_en   = cmd.fill_write || cmd.write_hit;
   assign wr_addr = cmd.fill_write ? pos_ff : req_off;

   always_comb begin
      case (cmd.rd_sel)
         RSEL_OFFSET:  rd_addr = req_off;
         RSEL_PENDING: rd_addr = pend_off_ff;
         RSEL_SCAN:    rd_addr = idx_ff;
         default:      rd_addr = req_off;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) line_mem_ff[wr_addr] <= data_ff;
      if (cmd.mem_rd) rd_data_ff <= line_mem_ff[rd_addr];
   end

   always_comb begin
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      data_in     = data_ff;
      ok_in       = ok_ff;
      tag_in      = tag_ff;
      valid_in    = valid_ff;
      modified_in = modified_ff;
      pending_in  = pending_ff;
      pos_in      = pos_ff;
      pend_off_in = pend_off_ff;
      dirty_in    = dirty_ff;
      idx_in      = idx_ff;
      prev_in     = prev_ff;

      if (cmd.capture) begin
         cmd_in  = cmd_type'(req_command);
         addr_in = req_address;
         data_in = req_byte_data;
         ok_in   = req_fill_ok;
      end
      if (cmd.fill_write) begin
         pos_in = pos_ff + 1'b1;
      end
      if (cmd.fill_done) begin
         pos_in     = '0;
         pending_in = 1'b0;
         valid_in   = 1'b1;
      end
      if (cmd.fill_fail) begin
         pos_in     = '0;
         pending_in = 1'b0;
      end
      if (cmd.write_hit) begin
         dirty_in[req_off] = 1'b1;
         valid_in          = 1'b0;
         modified_in       = 1'b1;
         tag_in            = req_tag;
      end
      if (cmd.fill_req) begin
         tag_in      = req_tag;
         valid_in    = 1'b0;
         pending_in  = 1'b1;
         pos_in      = '0;
         pend_off_in = req_off;
      end
      if (cmd.scan_start) begin
         idx_in  = '0;
         prev_in = 1'b0;
      end
      if (cmd.scan_next) begin
         idx_in  = idx_ff + 1'b1;
         prev_in = cmd.scan_hit;
      end
      if (cmd.scan_end) begin
         dirty_in    = '0;
         modified_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      maddr_in     = maddr_ff;
      odata_in     = odata_ff;
      rs_in        = rs_ff;
      rok_in       = rok_ff;
      last_in      = last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         maddr_in     = '0;
         odata_in     = '0;
         rs_in        = 1'b0;
         rok_in       = 1'b0;
         last_in      = 1'b1;
         case (cmd.out_sel)
            OSEL_READ: begin
               kind_in  = KIND_READ;
               odata_in = rd_data_ff;
               rok_in   = 1'b1;
            end
            OSEL_FAIL: begin
               kind_in = KIND_READ;
            end
            OSEL_FILL_REQ: begin
               kind_in  = KIND_FILL_REQ;
               maddr_in = {req_tag, {OFF_W{1'b0}}};
            end
            OSEL_WB: begin
               kind_in  = KIND_WB;
               maddr_in = {tag_ff, idx_ff};
               odata_in = rd_data_ff;
               rs_in    = !prev_ff;
               last_in  = (cmd_ff == CMD_WRITE) && !more_dirty;
            end
            OSEL_DONE: begin
               kind_in = KIND_DONE;
            end
            default: begin
               kind_in = KIND_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff       <= '0;
         valid_ff     <= 1'b0;
         modified_ff  <= 1'b0;
         pending_ff   <= 1'b0;
         pos_ff       <= '0;
         pend_off_ff  <= '0;
         dirty_ff     <= '0;
         idx_ff       <= '0;
         prev_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag_ff       <= tag_in;
         valid_ff     <= valid_in;
         modified_ff  <= modified_in;
         pending_ff   <= pending_in;
         pos_ff       <= pos_in;
         pend_off_ff  <= pend_off_in;
         dirty_ff     <= dirty_in;
         idx_ff       <= idx_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      addr_ff  <= addr_in;
      data_ff  <= data_in;
      ok_ff    <= ok_in;
      kind_ff  <= kind_in;
      maddr_ff <= maddr_in;
      odata_ff <= odata_in;
      rs_ff    <= rs_in;
      rok_ff   <= rok_in;
      last_ff  <= last_in;
   end

   always_comb begin
      st.cmd         = cmd_ff;
      st.fill_ok     = ok_ff;
      st.pending     = pending_ff;
      st.modified    = modified_ff;
      st.valid       = valid_ff;
      st.tag_hit     = (req_tag == tag_ff);
      st.fill_last   = (pos_ff == OFF_W'(LINE_BYTES - 1));
      st.scan_dirty  = dirty_ff[idx_ff];
      st.scan_at_end = (idx_ff == OFF_W'(LINE_BYTES - 1));
      st.out_free    = out_free;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_mem_address = maddr_ff;
   assign rsp_out_data    = odata_ff;
   assign rsp_run_start   = rs_ff;
   assign rsp_read_ok     = rok_ff;
   assign rsp_last        = last_ff;

   a_modified_has_dirty: assert property (@(posedge clock) disable iff (reset)
      modified_ff |-> (dirty_ff != '0))
      else $error("line modified without dirty bytes");

   a_clean_while_filling: assert property (@(posedge clock) disable iff (reset)
      pending_ff |-> !modified_ff)
      else $error("fill pending on a modified line");

   a_valid_is_clean: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !modified_ff)
      else $error("line readable while modified");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.out_load)
      else $error("result register overwritten while stalled");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import elwbc_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int ITEM_TARGET = 110;

   typedef struct packed {
      cmd_type             command;
      logic [ADDR_W-1:0]   address;
      logic [DATA_W-1:0]   byte_data;
      logic                fill_ok;
   } cache_req_type;

   typedef struct packed {
      kind_type            kind;
      logic [ADDR_W-1:0]   mem_address;
      logic [DATA_W-1:0]   out_data;
      logic                run_start;
      logic                read_ok;
      logic                last;
   } cache_rsp_type;

   typedef struct packed {
      logic [LINE_BYTES-1:0][DATA_W-1:0] data;
      logic [LINE_BYTES-1:0]             dirty;
      logic [TAG_W-1:0]                  tag;
      logic                              valid;
      logic                              modified;
      logic                              filling;
      logic [OFF_W:0]                    fill_pos;
      logic [OFF_W-1:0]                  pend_off;
   } line_state_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_command = 2'd0;
   logic [ADDR_W-1:0]   req_address = '0;
   logic [DATA_W-1:0]   req_byte_data = '0;
   logic                req_fill_ok = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [1:0]          rsp_kind;
   logic [ADDR_W-1:0]   rsp_mem_address;
   logic [DATA_W-1:0]   rsp_out_data;
   logic                rsp_run_start;
   logic                rsp_read_ok;
   logic                rsp_last;

   cache_req_type       pending_reqs[$];
   cache_rsp_type       due_results[$];
   line_state_type      line_gen = '0;
   line_state_type      line_now = '0;
   cache_req_type       on_wire;
   cache_rsp_type       want;
   logic [TAG_W-1:0]    tag_pool[4];
   int unsigned         accepted = 0;
   int unsigned         total_reqs = 0;
   int unsigned         results_seen = 0;
   int unsigned         mismatches = 0;
   int unsigned         burst_left = 0;
   int unsigned         gap_left = 0;
   int unsigned         hold_left = 0;
   logic                hold_done = 1'b0;
   int unsigned         mode_left = 0;
   int unsigned         ready_mode = 0;

   eeprom_line_write_back_cache_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_address     (req_address),
      .req_byte_data   (req_byte_data),
      .req_fill_ok     (req_fill_ok),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_mem_address (rsp_mem_address),
      .rsp_out_data    (rsp_out_data),
      .rsp_run_start   (rsp_run_start),
      .rsp_read_ok     (rsp_read_ok),
      .rsp_last        (rsp_last)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic cache_rsp_type make_result(input kind_type k,
                                                 input logic [ADDR_W-1:0] a,
                                                 input logic [DATA_W-1:0] d, input logic rs,
                                                 input logic ok);
      cache_rsp_type r;
      r.kind        = k;
      r.mem_address = a;
      r.out_data    = d;
      r.run_start   = rs;
      r.read_ok     = ok;
      r.last        = 1'b0;
      return r;
   endfunction

   // Next line state for one transaction; results go to due_results when record is set.
   function automatic line_state_type apply_cache_op(input line_state_type c,
                                                     input cache_req_type t,
                                                     input logic record);
      cache_rsp_type    outs[$];
      cache_rsp_type    r;
      logic [TAG_W-1:0] tag;
      logic [OFF_W-1:0] off;
      logic             do_flush;
      logic             prev;
      tag      = t.address[ADDR_W-1:OFF_W];
      off      = t.address[OFF_W-1:0];
      do_flush = 1'b0;
      if (c.filling) begin
         if (t.command == CMD_FILL) begin
            if (!t.fill_ok) begin
               c.data     = {LINE_BYTES{8'hFF}};
               c.filling  = 1'b0;
               c.fill_pos = '0;
               outs.push_back(make_result(KIND_READ, '0, '0, 1'b0, 1'b0));
            end else begin
               c.data[c.fill_pos[OFF_W-1:0]] = t.byte_data;
               c.fill_pos = c.fill_pos + 1'b1;
               if (c.fill_pos == LINE_BYTES) begin
                  c.filling  = 1'b0;
                  c.fill_pos = '0;
                  c.valid    = 1'b1;
                  outs.push_back(make_result(KIND_READ, '0, c.data[c.pend_off], 1'b0, 1'b1));
               end
            end
         end
      end else begin
         case (t.command)
            CMD_WRITE: do_flush = (tag != c.tag);
            CMD_READ:  do_flush = c.modified || (tag != c.tag);
            CMD_FLUSH: do_flush = 1'b1;
            default:   do_flush = 1'b0;
         endcase
         if (do_flush && c.modified) begin
            prev = 1'b0;
            for (int i = 0; i < LINE_BYTES; i++) begin
               if (c.dirty[i]) begin
                  outs.push_back(make_result(KIND_WB, {c.tag, OFF_W'(i)}, c.data[i], !prev,
                                             1'b0));
                  prev = 1'b1;
               end else begin
                  prev = 1'b0;
               end
            end
            c.dirty    = '0;
            c.modified = 1'b0;
         end
         if (do_flush && t.command != CMD_FLUSH) begin
            c.tag   = tag;
            c.valid = 1'b0;
         end
         case (t.command)
            CMD_WRITE: begin
               c.data[off]  = t.byte_data;
               c.dirty[off] = 1'b1;
               c.valid      = 1'b0;
               c.modified   = 1'b1;
            end
            CMD_READ: begin
               if (!c.valid) begin
                  c.filling  = 1'b1;
                  c.fill_pos = '0;
                  c.pend_off = off;
                  outs.push_back(make_result(KIND_FILL_REQ, {c.tag, {OFF_W{1'b0}}}, '0, 1'b0,
                                             1'b0));
               end else begin
                  outs.push_back(make_result(KIND_READ, '0, c.data[off], 1'b0, 1'b1));
               end
            end
            CMD_FLUSH: outs.push_back(make_result(KIND_DONE, '0, '0, 1'b0, 1'b0));
            default: ;
         endcase
      end
      if (record) begin
         foreach (outs[k]) begin
            r      = outs[k];
            r.last = (k == outs.size() - 1);
            due_results.push_back(r);
         end
      end
      return c;
   endfunction

   task automatic queue_req(input cmd_type c, input logic [ADDR_W-1:0] a,
                            input logic [DATA_W-1:0] d, input logic ok);
      cache_req_type t;
      t.command   = c;
      t.address   = a;
      t.byte_data = d;
      t.fill_ok   = ok;
      pending_reqs.push_back(t);
      line_gen = apply_cache_op(line_gen, t, 1'b0);
   endtask

   function automatic logic [ADDR_W-1:0] pick_address();
      logic [OFF_W-1:0] off;
      off = OFF_W'($urandom);
      if ($urandom_range(0, 5) == 0)
         return ADDR_W'($urandom);
      if ($urandom_range(0, 1) == 1)
         return {line_gen.tag, off};
      return {tag_pool[$urandom_range(0, 3)], off};
   endfunction

   // Supplies fill bytes until the pending line fill ends; err_at >= LINE_BYTES means no error.
   task automatic feed_line_fill(input int err_at);
      int pos;
      pos = 0;
      while (line_gen.filling) begin
         if ($urandom_range(0, 15) == 0) begin
            queue_req(cmd_type'(2'($urandom_range(0, 2))), pick_address(), DATA_W'($urandom),
                      1'($urandom));
         end else begin
            queue_req(CMD_FILL, ADDR_W'($urandom), DATA_W'($urandom), pos != err_at);
            pos++;
         end
      end
   endtask

   task automatic note_mismatch(input string msg);
      $display("result %0d: %s", results_seen, msg);
      mismatches++;
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            line_now = apply_cache_op(line_now, on_wire, 1'b1);
            accepted <= accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0 || pending_reqs.size() == 0) begin
               if (gap_left != 0)
                  gap_left--;
               req_valid <= 1'b0;
            end else begin
               on_wire = pending_reqs.pop_front();
               req_valid     <= 1'b1;
               req_command   <= on_wire.command;
               req_address   <= on_wire.address;
               req_byte_data <= on_wire.byte_data;
               req_fill_ok   <= on_wire.fill_ok;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // long receiver hold-off, once
   always @(posedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted >= 40) begin
            hold_left <= 400;
            hold_done <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (ready_mode)
            0:       rsp_ready <= (hold_left == 0);
            1:       rsp_ready <= (hold_left == 0) && ($urandom_range(0, 1) == 1);
            default: rsp_ready <= (hold_left == 0) && ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_results.size() == 0) begin
            note_mismatch($sformatf("unexpected transaction, kind %0d", rsp_kind));
         end else begin
            want = due_results.pop_front();
            if (rsp_kind != want.kind)
               note_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
            if (rsp_mem_address != want.mem_address)
               note_mismatch($sformatf("mem_address %h, want %h", rsp_mem_address,
                                       want.mem_address));
            if (rsp_out_data != want.out_data)
               note_mismatch($sformatf("out_data %h, want %h", rsp_out_data, want.out_data));
            if (rsp_run_start != want.run_start)
               note_mismatch($sformatf("run_start %b, want %b", rsp_run_start, want.run_start));
            if (rsp_read_ok != want.read_ok)
               note_mismatch($sformatf("read_ok %b, want %b", rsp_read_ok, want.read_ok));
            if (rsp_last != want.last)
               note_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
         end
         results_seen++;
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb NOT OK");
      $finish;
   end

   initial begin
      int               k;
      int               sel;
      int               s;
      int               st;
      logic [ADDR_W-1:0] a;
      tag_pool[0] = '0;
      tag_pool[1] = '1;
      tag_pool[2] = TAG_W'($urandom);
      tag_pool[3] = TAG_W'($urandom);

      // directed
      queue_req(CMD_FLUSH, 19'h00000, 8'h00, 1'b0);
      queue_req(CMD_FILL,  19'h7FFFF, 8'hFF, 1'b1);
      queue_req(CMD_WRITE, 19'h7FFFF, 8'hFF, 1'b1);
      queue_req(CMD_WRITE, 19'h7FFFE, 8'h00, 1'b0);
      queue_req(CMD_WRITE, 19'h7FFE0, 8'hA5, 1'b0);
      queue_req(CMD_FLUSH, 19'h7FFFF, 8'hFF, 1'b1);
      queue_req(CMD_WRITE, 19'h00000, 8'h5A, 1'b0);
      queue_req(CMD_WRITE, 19'h00021, 8'h3C, 1'b1);
      queue_req(CMD_READ,  19'h00021, 8'h00, 1'b0);
      queue_req(CMD_WRITE, 19'h00022, 8'h99, 1'b1);
      queue_req(CMD_READ,  19'h00021, 8'h00, 1'b0);
      queue_req(CMD_FLUSH, 19'h00000, 8'h00, 1'b0);
      queue_req(CMD_FILL,  19'h00000, 8'h11, 1'b0);
      queue_req(CMD_READ,  19'h7FFFF, 8'h00, 1'b1);
      feed_line_fill(LINE_BYTES);
      queue_req(CMD_READ,  19'h7FFE3, 8'h00, 1'b0);
      queue_req(CMD_READ,  19'h00000, 8'h00, 1'b0);
      feed_line_fill(5);
      queue_req(CMD_READ,  19'h00000, 8'h00, 1'b1);
      feed_line_fill(LINE_BYTES - 1);

      // random
      while (pending_reqs.size() < ITEM_TARGET) begin
         sel = $urandom_range(0, 99);
         if (sel < 6) begin
            a  = pick_address();
            s  = $urandom_range(0, LINE_BYTES - 1);
            st = 2 * $urandom_range(0, LINE_BYTES / 2 - 1) + 1;
            for (k = 0; k < LINE_BYTES; k++)
               queue_req(CMD_WRITE, {a[ADDR_W-1:OFF_W], OFF_W'(s + k * st)},
                         DATA_W'($urandom), 1'($urandom));
         end else if (sel < 45) begin
            queue_req(CMD_WRITE, pick_address(), DATA_W'($urandom), 1'($urandom));
         end else if (sel < 80) begin
            queue_req(CMD_READ, pick_address(), DATA_W'($urandom), 1'($urandom));
         end else if (sel < 93) begin
            queue_req(CMD_FLUSH, pick_address(), DATA_W'($urandom), 1'($urandom));
         end else begin
            queue_req(CMD_FILL, pick_address(), DATA_W'($urandom), 1'($urandom));
         end
         if (line_gen.filling)
            feed_line_fill(($urandom_range(0, 9) == 0) ? $urandom_range(0, LINE_BYTES - 1)
                                                       : LINE_BYTES);
      end
      total_reqs = pending_reqs.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (accepted != total_reqs) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/elwbc_pkg.sv
hw/rtl/elwbc_ctrl.sv
hw/rtl/elwbc_dp.sv
hw/rtl/eeprom_line_write_back_cache_core.sv
tb/tb.sv
